// ===== rtl/tile_background_layer_dot_defines.svh =====
// Assertion macros for the tile background layer.
`ifndef TILE_BACKGROUND_LAYER_DOT_DEFINES_SVH
`define TILE_BACKGROUND_LAYER_DOT_DEFINES_SVH
`ifndef SYNTHESIS
`define TBL_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TBL_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TBL_ASSERT_IMPL(label, clk, rst_n, a, c)
`define TBL_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/tbl_pkg.sv =====
// Shared types and constants of the tile background layer.
package tbl_pkg;
    localparam int LAYER_INDEX_DEFAULT = 0;
    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_LINE  = 2'd1;
    localparam logic [1:0] MODE_DOT   = 2'd2;
    localparam logic [2:0] REG_SCREEN_MODE = 3'd0;
    localparam logic [2:0] REG_LAYER_CTRL  = 3'd1;
    localparam logic [2:0] REG_TILE_DATA   = 3'd2;
    localparam logic [2:0] REG_TILE_MAP    = 3'd3;
    localparam logic [2:0] REG_PRIO_MOS    = 3'd4;
    localparam logic [2:0] REG_SCROLL      = 3'd5;
    localparam logic [2:0] REG_THIRD       = 3'd6;

    typedef struct packed {
        logic        req;
        logic        wr;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;
endpackage

// ===== rtl/tbl_vram.sv =====
// Video memory with a registered read and a clearing sweep after reset.
module tbl_vram (
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_pkg::mem_req_t mreq,
    output logic [7:0]       rdata,
    output logic             clearing
);
    import tbl_pkg::*;

    logic [7:0]  mem [0:65535];
    logic [16:0] clr_reg;

    assign clearing = !clr_reg[16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_reg + 17'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_reg[15:0]] <= 8'd0;
        end
        else if (mreq.req && mreq.wr)
        begin
            mem[mreq.addr] <= mreq.wdata;
        end
        rdata <= mem[mreq.addr];
    end
endmodule

// ===== rtl/tile_background_layer_dot.sv =====
// Top level of the tile background layer: sequencer, registers and result holds.
//
// One tile background layer. A video memory write, a scanline start, an
// unused mode or a skipped dot goes from the accepting state straight to
// the result state. A dot that draws is fastest with 2 bits per pixel and
// no offset-per-tile and slowest with 8 bits per pixel and both
// offset-per-tile entries, and it also waits for every subtraction of the
// mosaic quantization. The time is set by the single-port video memory,
// which is read one byte at a time (two bytes for each of up to two
// offset-per-tile entries, two map bytes, and up to eight plane bytes),
// each read presenting the address in one state and taking the registered
// data in the state that follows. The quantization of the dot position
// repeatedly subtracts the mosaic size from x, so it is slowest with a
// small mosaic size: most of all when mosaic is off and the dot counter is
// near its top. A result is held until the receiver takes it. After reset
// the memory is cleared by a sweep over all 65536 addresses during which
// no request is accepted.
// One request gives one result, the held main and sub values after it.
`include "tile_background_layer_dot_defines.svh"
module tile_background_layer_dot #(
    parameter int LAYER_INDEX = tbl_pkg::LAYER_INDEX_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [15:0] mem_address,
    input  logic [7:0]  mem_data,
    input  logic [8:0]  line_number,
    input  logic        field_odd,
    input  logic        dot_phase,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [10:0] main_palette,
    output logic [3:0]  main_priority,
    output logic [10:0] sub_palette,
    output logic [3:0]  sub_priority,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [35:0] cfg_data
);
    import tbl_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DIV   = 11'b00000000010,
        S_OPT   = 11'b00000000100,
        S_OPTRD = 11'b00000001000,
        S_MAP   = 11'b00000010000,
        S_MAPRD = 11'b00000100000,
        S_TILE  = 11'b00001000000,
        S_PLANE = 11'b00010000000,
        S_PLRD  = 11'b00100000000,
        S_DONE  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg;

    logic [2:0]  smode_reg;
    logic [7:0]  lctl_reg;
    logic [15:0] tdb_reg, tmb_reg;
    logic [11:0] pm_reg;
    logic [19:0] scr_reg;
    logic [35:0] third_reg;

    logic [11:0] dot_reg;
    logic [9:0]  mline_reg;
    logic [4:0]  mcd_reg;
    logic [10:0] mpal_reg, spal_reg;
    logic [3:0]  mpri_reg, spri_reg;

    // Per-dot working registers.
    logic [11:0] x_reg, rem_reg;
    logic [15:0] hoff_reg, voff_reg;
    logic [15:0] hval_reg, vval_reg;
    logic [1:0]  ocnt_reg;
    logic        lo_reg;
    logic [7:0]  byte_lo_reg;
    logic [15:0] entry_reg;
    logic [2:0]  pcnt_reg;
    logic [7:0]  color_reg;
    logic        fld_reg;

    mem_req_t    mreq;
    logic [7:0]  rdata;
    logic        clearing;

    tbl_vram u_vram (
        .clk     (clk),
        .rst_n   (rst_n),
        .mreq    (mreq),
        .rdata   (rdata),
        .clearing(clearing)
    );

    // Decoded configuration.
    logic        hires, opt_on, th4, tw4;
    logic [1:0]  fmt, cd, ss;
    logic [3:0]  mos;
    logic [15:0] width, mask_x, mask_y, scr_x, scr_y, hscroll, vscroll, y_eff;
    logic [4:0]  mos1;

    always_comb
    begin
        hires   = (smode_reg == 3'd5) || (smode_reg == 3'd6);
        opt_on  = ((smode_reg == 3'd2) || (smode_reg == 3'd4) || (smode_reg == 3'd6))
                  && (LAYER_INDEX == 0 || LAYER_INDEX == 1);
        fmt     = lctl_reg[1:0];
        cd      = fmt - 2'd1;
        ss      = lctl_reg[4:3];
        mos     = pm_reg[11:8];
        mos1    = {1'b0, mos} + 5'd1;
        th4     = lctl_reg[2];
        tw4     = hires | th4;
        width   = hires ? 16'd512 : 16'd256;
        mask_x  = th4 ? (width << 1) : width;
        mask_y  = mask_x;
        if (ss[0]) mask_x = mask_x << 1;
        if (ss[1]) mask_y = mask_y << 1;
        mask_x  = mask_x - 16'd1;
        mask_y  = mask_y - 16'd1;
        scr_y   = ss[1] ? 16'd1024 : 16'd0;
        scr_x   = ss[0] ? 16'd1024 : 16'd0;
        if (ss == 2'd3) scr_y = scr_y << 1;
        hscroll = {6'd0, scr_reg[9:0]};
        vscroll = {6'd0, scr_reg[19:10]};
        y_eff   = {6'd0, mline_reg};
        if (hires)
        begin
            hscroll = hscroll << 1;
            if (lctl_reg[7]) y_eff = (y_eff << 1) + {15'd0, fld_reg};
        end
    end

    // Offset-per-tile fetch address for entry ocnt (0 = h, 1 = v, 2/3 not used).
    logic [15:0] optx, opt_px, opt_py, opt_addr;
    logic [15:0] opt_tx, opt_ty;
    always_comb
    begin
        optx   = {4'd0, x_reg} + {13'd0, hscroll[2:0]};
        opt_px = (optx - 16'd8) + {6'd0, third_reg[9:3], 3'd0};
        opt_py = {6'd0, third_reg[19:10]} + (ocnt_reg[0] ? 16'd8 : 16'd0);
        opt_tx = (opt_px & (width - 16'd1)) >> (tw4 ? 4 : 3);
        opt_ty = (opt_py & (width - 16'd1)) >> (th4 ? 4 : 3);
        opt_addr = third_reg[35:20] + {5'd0, opt_ty[4:0], opt_tx[4:0], 1'b0};
    end

    // Map address from the final offsets.
    logic [15:0] mhoff, mvoff, mtx, mty, mpos, map_addr;
    always_comb
    begin
        mhoff = hoff_reg & mask_x;
        mvoff = voff_reg & mask_y;
        mtx   = mhoff >> (tw4 ? 4 : 3);
        mty   = mvoff >> (th4 ? 4 : 3);
        mpos  = {6'd0, mty[4:0], mtx[4:0]};
        if (mty[5]) mpos = mpos + scr_y;
        if (mtx[5]) mpos = mpos + scr_x;
        map_addr = tmb_reg + {mpos[14:0], 1'b0};
    end

    // Tile and plane base.
    logic        mir_y, mir_x;
    logic [15:0] tile, tmask, tdi, tbase, hf, vf;
    logic [7:0]  bitm;
    always_comb
    begin
        mir_y = entry_reg[15];
        mir_x = entry_reg[14];
        tile  = entry_reg;
        if (tw4 && (mhoff[3] != mir_x)) tile = tile + 16'd1;
        if (th4 && (mvoff[3] != mir_y)) tile = tile + 16'd16;
        tile  = tile & 16'h03ff;
        tdi   = tdb_reg >> (3'd4 + {1'b0, cd});
        tmask = 16'h0fff >> cd;
        tile  = (tile + tdi) & tmask;
        vf    = mir_y ? (mvoff ^ 16'd7) : mvoff;
        hf    = mir_x ? (mhoff ^ 16'd7) : mhoff;
        tbase = (tile << (3'd4 + {1'b0, cd})) + {12'd0, vf[2:0], 1'b0};
        bitm  = 8'h80 >> hf[2:0];
    end

    logic [2:0]  nplanes_m1;
    logic [15:0] plane_off;
    assign nplanes_m1 = (cd == 2'd0) ? 3'd1 : ((cd == 2'd1) ? 3'd3 : 3'd7);
    assign plane_off  = {11'd0, pcnt_reg[2:1], 3'd0} << 1 | {15'd0, pcnt_reg[0]};

    logic        draw_ok, is_dot_skip;
    assign is_dot_skip = (dot_phase && !hires) || (fmt == 2'd0)
                         || (!lctl_reg[5] && !lctl_reg[6]);

    logic [3:0]  prio;
    logic [2:0]  pal_num;
    logic [7:0]  pal_index, colfin;
    logic        to_main, to_sub;
    always_comb
    begin
        prio      = entry_reg[13] ? pm_reg[7:4] : pm_reg[3:0];
        pal_num   = entry_reg[12:10];
        pal_index = ((smode_reg == 3'd0) ? 8'(LAYER_INDEX << 5) : 8'd0)
                    + 8'({5'd0, pal_num} << (4'd2 << cd));
        colfin    = color_reg + pal_index;
        to_main   = hires ? x_reg[0] : 1'b1;
        to_sub    = hires ? !x_reg[0] : 1'b1;
        draw_ok   = color_reg != 8'd0;
    end

    assign in_ready  = (state_reg == S_IDLE) && !clearing;
    assign out_valid = (state_reg == S_OUT);
    assign main_palette  = mpal_reg;
    assign main_priority = mpri_reg;
    assign sub_palette   = spal_reg;
    assign sub_priority  = spri_reg;

    // The read address is presented in the issuing state, so the registered
    // byte is on rdata in the state that follows.
    always_comb
    begin
        mreq.req   = 1'b0;
        mreq.wr    = 1'b0;
        mreq.wdata = mem_data;
        unique case (state_reg)
            S_OPT:   mreq.addr = opt_addr + (lo_reg ? 16'd0 : 16'd1);
            S_MAP:   mreq.addr = map_addr + (lo_reg ? 16'd0 : 16'd1);
            S_PLANE: mreq.addr = tbase + plane_off;
            default: mreq.addr = mem_address;
        endcase
        if (in_valid && in_ready && mode == MODE_WRITE)
        begin
            mreq.req  = 1'b1;
            mreq.wr   = 1'b1;
            mreq.addr = mem_address;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smode_reg <= '0; lctl_reg <= '0; tdb_reg <= '0; tmb_reg <= '0;
            pm_reg <= '0; scr_reg <= '0; third_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SCREEN_MODE: smode_reg <= cfg_data[2:0];
                REG_LAYER_CTRL:  lctl_reg  <= cfg_data[7:0];
                REG_TILE_DATA:   tdb_reg   <= cfg_data[15:0];
                REG_TILE_MAP:    tmb_reg   <= cfg_data[15:0];
                REG_PRIO_MOS:    pm_reg    <= cfg_data[11:0];
                REG_SCROLL:      scr_reg   <= cfg_data[19:0];
                REG_THIRD:       third_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dot_reg <= '0; mline_reg <= '0; mcd_reg <= '0;
            mpal_reg <= '0; spal_reg <= '0; mpri_reg <= '0; spri_reg <= '0;
            x_reg <= '0; rem_reg <= '0; hoff_reg <= '0; voff_reg <= '0;
            hval_reg <= '0; vval_reg <= '0; ocnt_reg <= '0; lo_reg <= 1'b1;
            byte_lo_reg <= '0; entry_reg <= '0; pcnt_reg <= '0; color_reg <= '0;
            fld_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        state_reg <= S_OUT;
                        fld_reg   <= field_odd;
                        if (mode == MODE_LINE)
                        begin
                            if (line_number == 9'd1)
                            begin
                                mline_reg <= 10'd1;
                                mcd_reg   <= 5'd0;
                            end
                            else
                            begin
                                if (mos == 4'd0 || mcd_reg == 5'd0)
                                    mline_reg <= {1'b0, line_number};
                                mcd_reg <= ((mcd_reg == 5'd0) ? mos1 : mcd_reg) - 5'd1;
                            end
                            dot_reg <= '0;
                        end
                        else if (mode == MODE_DOT)
                        begin
                            if (!dot_phase)
                            begin
                                mpri_reg <= '0;
                                spri_reg <= '0;
                            end
                            if (!is_dot_skip)
                            begin
                                x_reg    <= dot_reg;
                                rem_reg  <= dot_reg;
                                dot_reg  <= dot_reg + 12'd1;
                                state_reg <= S_DIV;
                            end
                        end
                    end
                end
                S_DIV:
                begin
                    // Quantize x to the mosaic size by repeated subtraction.
                    if (rem_reg >= {7'd0, mos1})
                        rem_reg <= rem_reg - {7'd0, mos1};
                    else
                    begin
                        hoff_reg <= hscroll + {4'd0, x_reg - rem_reg};
                        voff_reg <= vscroll + y_eff;
                        hval_reg <= '0;
                        vval_reg <= '0;
                        ocnt_reg <= '0;
                        lo_reg   <= 1'b1;
                        state_reg <= (opt_on && optx >= 16'd8) ? S_OPT : S_MAP;
                    end
                end
                S_OPT:
                begin
                    state_reg <= S_OPTRD;
                end
                S_OPTRD:
                begin
                    // The byte addressed in the previous cycle is on rdata now.
                    state_reg <= S_OPT;
                    if (lo_reg)
                    begin
                        byte_lo_reg <= rdata;
                        lo_reg <= 1'b0;
                    end
                    else
                    begin
                        lo_reg <= 1'b1;
                        if (ocnt_reg[0]) vval_reg <= {rdata, byte_lo_reg};
                        else hval_reg <= {rdata, byte_lo_reg};
                        ocnt_reg <= ocnt_reg + 2'd1;
                        if (ocnt_reg[0] || smode_reg == 3'd4)
                            state_reg <= S_TILE;
                    end
                end
                S_TILE:
                begin
                    // Apply offset-per-tile results.
                    if (ocnt_reg != 2'd0)
                    begin
                        if (smode_reg == 3'd4)
                        begin
                            if (hval_reg[LAYER_INDEX == 0 ? 13 : 14])
                            begin
                                if (!hval_reg[15])
                                    hoff_reg <= optx + {hval_reg[15:3], 3'd0};
                                else
                                    voff_reg <= y_eff + hval_reg;
                            end
                        end
                        else
                        begin
                            if (hval_reg[LAYER_INDEX == 0 ? 13 : 14])
                                hoff_reg <= optx + {hval_reg[15:3], 3'd0};
                            if (vval_reg[LAYER_INDEX == 0 ? 13 : 14])
                                voff_reg <= y_eff + vval_reg;
                        end
                        ocnt_reg <= '0;
                    end
                    lo_reg    <= 1'b1;
                    state_reg <= S_MAP;
                end
                S_MAP:
                begin
                    state_reg <= S_MAPRD;
                end
                S_MAPRD:
                begin
                    state_reg <= S_MAP;
                    if (lo_reg)
                    begin
                        byte_lo_reg <= rdata;
                        lo_reg <= 1'b0;
                    end
                    else
                    begin
                        entry_reg <= {rdata, byte_lo_reg};
                        pcnt_reg  <= '0;
                        color_reg <= '0;
                        state_reg <= S_PLANE;
                    end
                end
                S_PLANE:
                begin
                    state_reg <= S_PLRD;
                end
                S_PLRD:
                begin
                    // The plane byte addressed in the previous cycle is on rdata now.
                    color_reg[pcnt_reg] <= (rdata & bitm) != 8'd0;
                    pcnt_reg <= pcnt_reg + 3'd1;
                    state_reg <= (pcnt_reg == nplanes_m1) ? S_DONE : S_PLANE;
                end
                S_DONE:
                begin
                    if (draw_ok)
                    begin
                        if (to_main && lctl_reg[5])
                        begin
                            mpal_reg <= {pal_num, colfin};
                            mpri_reg <= prio;
                        end
                        if (to_sub && lctl_reg[6])
                        begin
                            spal_reg <= {pal_num, colfin};
                            spri_reg <= prio;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `TBL_ASSERT_IMPL(a_no_ready_busy, clk, rst_n, state_reg != S_IDLE, !in_ready)
    `TBL_ASSERT_IMPL(a_no_accept_clear, clk, rst_n, clearing, !in_ready)
    `TBL_ASSERT_NEXT(a_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid)
    `TBL_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && !out_ready, $stable(main_palette))
endmodule

// ===== sim/tile_background_layer_dot_tb.sv =====
// Self-checking testbench for the tile background layer with its own layer predictor.
`timescale 1ns / 100ps

module tile_background_layer_dot_tb;
    import tbl_pkg::*;

    // Clock, reset and all block inputs start at known values.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  mode = MODE_WRITE;
    logic [15:0] mem_address = '0;
    logic [7:0]  mem_data = '0;
    logic [8:0]  line_number = '0;
    logic        field_odd = 1'b0;
    logic        dot_phase = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [10:0] main_palette;
    logic [3:0]  main_priority;
    logic [10:0] sub_palette;
    logic [3:0]  sub_priority;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [35:0] cfg_data = '0;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned LAYER = 0;

    typedef struct {
        logic [10:0] main_pal;
        logic [3:0]  main_prio;
        logic [10:0] sub_pal;
        logic [3:0]  sub_prio;
    } pixel_hold_t;

    // Predicted layer state, kept in step with every accepted request.
    logic [7:0]  vram [0:65535];
    logic [11:0] dot_count;
    logic [9:0]  mosaic_row;
    logic [4:0]  mosaic_left;
    pixel_hold_t held;
    logic [2:0]  bg_mode;
    logic [7:0]  layer_ctrl;
    logic [15:0] char_base;
    logic [15:0] map_base;
    logic [11:0] prio_mosaic;
    logic [19:0] scroll;
    logic [35:0] bg3_source;

    pixel_hold_t pending_pixels [$];
    int unsigned errors = 0;
    int unsigned results_seen = 0;
    int unsigned requests_sent = 0;
    int unsigned dots_drawn = 0;
    bit          quiet = 1'b0;
    int unsigned stall_left = 0;

    tile_background_layer_dot #(.LAYER_INDEX(LAYER)) i_dut (.*);

    always #2 clk = ~clk;

    // Generous fixed limit: the clearing sweep plus the slowest dots, many times over.
    initial
    begin
        #20000000;
        $display("tile_background_layer_dot verification failed");
        $finish;
    end

    function automatic int unsigned vram_word(input int unsigned a);
        return int'(vram[a & 16'hffff]) | (int'(vram[(a + 1) & 16'hffff]) << 8);
    endfunction

    function automatic int unsigned plane(input int unsigned a, input int unsigned m);
        return ((vram[a & 16'hffff] & m) != 0) ? 1 : 0;
    endfunction

    // Reads one offset-per-tile entry from the third layer's map.
    function automatic int unsigned bg3_entry(input int unsigned optx, input int unsigned py,
                                              input int unsigned width,
                                              input int unsigned tw, input int unsigned th);
        int unsigned px, tx, ty, pos;
        px = (optx - 8) + (int'(bg3_source[9:0]) & ~32'd7);
        tx = (px & (width - 1)) >> tw;
        ty = (py & (width - 1)) >> th;
        pos = (((ty & 32'h1f) << 5) + (tx & 32'h1f)) & 32'hffff;
        return vram_word((int'(bg3_source[35:20]) + (pos << 1)) & 32'hffff);
    endfunction

    function automatic void start_scanline(input logic [8:0] ln);
        int unsigned mos, left;
        mos = prio_mosaic[11:8];
        if (ln == 9'd1)
        begin
            mosaic_row = 10'd1;
            mosaic_left = 5'd0;
        end
        else
        begin
            if (mos == 0 || mosaic_left == 0)
                mosaic_row = {1'b0, ln};
            left = (mosaic_left == 0) ? mos + 1 : mosaic_left;
            mosaic_left = 5'((left - 1) & 32'h1f);
        end
        dot_count = '0;
    endfunction

    // Renders one dot into the held main and sub values.
    function automatic void draw_dot(input logic fld, input logic phase);
        bit hires, main_en, sub_en, opt, mir_x, mir_y;
        int unsigned fmt, ss, mos, x, y, cd, pal_off, pal_shift, char_mask, td_index;
        int unsigned th, tw, width, mask_x, mask_y, scr_x, scr_y, hscroll, vscroll;
        int unsigned hoff, voff, optx, hval, vval, valid_bit, tx, ty, pos, entry;
        int unsigned prio, pal_num, pal_index, tile, m, base, color, pal;
        hires = (bg_mode == 3'd5 || bg_mode == 3'd6);
        fmt = layer_ctrl[1:0];
        main_en = layer_ctrl[5];
        sub_en = layer_ctrl[6];
        ss = layer_ctrl[4:3];
        mos = prio_mosaic[11:8];
        if (!phase)
        begin
            held.main_prio = '0;
            held.sub_prio = '0;
        end
        else if (!hires)
            return;
        if (fmt == 0 || (!main_en && !sub_en))
            return;
        x = dot_count;
        dot_count = dot_count + 12'd1;
        y = mosaic_row;
        cd = fmt - 1;
        pal_off = (bg_mode == 3'd0) ? (LAYER << 5) : 0;
        pal_shift = 2 << cd;
        char_mask = 32'h0fff >> cd;
        td_index = int'(char_base) >> (4 + cd);
        th = layer_ctrl[2] ? 4 : 3;
        tw = hires ? 4 : th;
        width = hires ? 512 : 256;
        mask_x = (th == 3) ? width : (width << 1);
        mask_y = mask_x;
        if (ss & 1) mask_x = mask_x << 1;
        if (ss & 2) mask_y = mask_y << 1;
        mask_x = mask_x - 1;
        mask_y = mask_y - 1;
        scr_y = (ss & 2) ? 1024 : 0;
        scr_x = (ss & 1) ? 1024 : 0;
        if (ss == 3) scr_y = scr_y << 1;
        hscroll = scroll[9:0];
        vscroll = scroll[19:10];
        if (hires)
        begin
            hscroll = hscroll << 1;
            if (layer_ctrl[7]) y = (y << 1) + fld;
        end
        hoff = hscroll + (x / (mos + 1)) * (mos + 1);
        voff = vscroll + y;
        // Offset-per-tile applies to the first two layers in modes 2, 4 and 6.
        opt = (bg_mode == 3'd2 || bg_mode == 3'd4 || bg_mode == 3'd6) && (LAYER <= 1);
        if (opt)
        begin
            optx = (x + (hscroll & 7)) & 32'hffff;
            if (optx >= 8)
            begin
                hval = bg3_entry(optx, bg3_source[19:10], width, tw, th);
                vval = 0;
                valid_bit = (LAYER == 0) ? 32'h2000 : 32'h4000;
                if (bg_mode != 3'd4)
                    vval = bg3_entry(optx, bg3_source[19:10] + 8, width, tw, th);
                if (bg_mode == 3'd4)
                begin
                    if (hval & valid_bit)
                    begin
                        if (!(hval & 32'h8000)) hoff = optx + (hval & ~32'd7);
                        else voff = y + hval;
                    end
                end
                else
                begin
                    if (hval & valid_bit) hoff = optx + (hval & ~32'd7);
                    if (vval & valid_bit) voff = y + vval;
                end
            end
        end
        hoff = hoff & mask_x;
        voff = voff & mask_y;
        tx = hoff >> tw;
        ty = voff >> th;
        pos = ((ty & 32'h1f) << 5) + (tx & 32'h1f);
        if (ty & 32'h20) pos = pos + scr_y;
        if (tx & 32'h20) pos = pos + scr_x;
        pos = pos & 32'hffff;
        entry = vram_word((int'(map_base) + (pos << 1)) & 32'hffff);
        mir_y = (entry & 32'h8000) != 0;
        mir_x = (entry & 32'h4000) != 0;
        prio = (entry & 32'h2000) ? prio_mosaic[7:4] : prio_mosaic[3:0];
        pal_num = (entry >> 10) & 7;
        pal_index = pal_off + (pal_num << pal_shift);
        tile = entry;
        if (tw == 4 && (((hoff & 8) != 0) != mir_x)) tile = tile + 1;
        if (th == 4 && (((voff & 8) != 0) != mir_y)) tile = tile + 16;
        tile = ((tile & 32'h03ff) + td_index) & char_mask;
        if (mir_y) voff = voff ^ 7;
        if (mir_x) hoff = hoff ^ 7;
        m = 32'h80 >> (hoff & 7);
        base = ((tile << (4 + cd)) + ((voff & 7) << 1)) & 32'hffff;
        color = plane(base, m) | (plane(base + 1, m) << 1);
        if (cd >= 1)
            color = color | (plane(base + 16, m) << 2) | (plane(base + 17, m) << 3);
        if (cd >= 2)
            color = color | (plane(base + 32, m) << 4) | (plane(base + 33, m) << 5)
                          | (plane(base + 48, m) << 6) | (plane(base + 49, m) << 7);
        // A transparent pixel leaves both holds as they were.
        if (color == 0)
            return;
        dots_drawn++;
        color = (color + pal_index) & 32'hff;
        pal = (color | (pal_num << 8)) & 32'h7ff;
        // In hires, odd dots go to the main screen and even dots to the sub screen.
        if ((!hires || (x & 1)) && main_en)
        begin
            held.main_pal = pal[10:0];
            held.main_prio = prio[3:0];
        end
        if ((!hires || !(x & 1)) && sub_en)
        begin
            held.sub_pal = pal[10:0];
            held.sub_prio = prio[3:0];
        end
    endfunction

    // Sends one request, waits for it to be taken, then predicts its result.
    // Valid stays high afterwards so that back-to-back requests need no gap.
    task automatic send_request(input logic [1:0] m, input logic [15:0] a, input logic [7:0] d,
                                input logic [8:0] ln, input logic fld, input logic phase);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        mem_address <= a;
        mem_data <= d;
        line_number <= ln;
        field_odd <= fld;
        dot_phase <= phase;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        case (m)
            MODE_WRITE: vram[a] = d;
            MODE_LINE:  start_scanline(ln);
            MODE_DOT:   draw_dot(fld, phase);
            default:    ;
        endcase
        pending_pixels.push_back(held);
    endtask

    // Lets the block drain, then writes one register and mirrors it.
    task automatic write_reg(input logic [2:0] idx, input logic [35:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SCREEN_MODE: bg_mode = value[2:0];
            REG_LAYER_CTRL:  layer_ctrl = value[7:0];
            REG_TILE_DATA:   char_base = value[15:0];
            REG_TILE_MAP:    map_base = value[15:0];
            REG_PRIO_MOS:    prio_mosaic = value[11:0];
            REG_SCROLL:      scroll = value[19:0];
            REG_THIRD:       bg3_source = value;
            default:         ;
        endcase
    endtask

    task automatic write_vram(input logic [15:0] a, input logic [7:0] d);
        send_request(MODE_WRITE, a, d, '0, 1'b0, 1'b0);
    endtask

    task automatic send_dot(input logic fld, input logic phase);
        send_request(MODE_DOT, 16'($urandom), 8'($urandom), 9'($urandom), fld, phase);
    endtask

    task automatic send_line(input logic [8:0] ln);
        send_request(MODE_LINE, 16'($urandom), 8'($urandom), ln, 1'($urandom), 1'($urandom));
    endtask

    // The receiver stalls in random bursts, except during the steady tail.
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end
        else if (!quiet && rst_n && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 16);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Every result is matched against the oldest predicted hold values.
    always @(posedge clk)
    begin
        pixel_hold_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_pixels.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: main %h/%h sub %h/%h", main_palette,
                             main_priority, sub_palette, sub_priority);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (want.main_pal !== main_palette || want.main_prio !== main_priority ||
                    want.sub_pal !== sub_palette || want.sub_prio !== sub_priority)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected %h/%h %h/%h, got %h/%h %h/%h",
                                 results_seen, want.main_pal, want.main_prio, want.sub_pal,
                                 want.sub_prio, main_palette, main_priority, sub_palette,
                                 sub_priority);
                end
            end
        end
    end

    // Fresh from reset everything reads as zero, including the unused mode.
    task automatic test_reset_state();
        send_request(MODE_UNUSED, 16'hffff, 8'hff, 9'h1ff, 1'b1, 1'b1);
        send_dot(1'b0, 1'b0);
    endtask

    // Hand-built tiles covering 2 and 8 bits per pixel, hires, offset-per-tile and the odd cases.
    task automatic test_directed_cases();
        write_reg(REG_SCREEN_MODE, 36'd1);
        write_reg(REG_LAYER_CTRL, 36'h61);
        write_reg(REG_TILE_DATA, 36'h0000);
        write_reg(REG_TILE_MAP, 36'h0800);
        write_reg(REG_PRIO_MOS, 36'h073);
        write_reg(REG_SCROLL, 36'h0);
        write_reg(REG_THIRD, 36'h0);
        write_vram(16'h0800, 8'h01);
        write_vram(16'h0801, 8'h20);
        write_vram(16'h0010, 8'hff);
        send_line(9'd0);
        send_dot(1'b0, 1'b0);
        // Odd phase outside hires is skipped and leaves the holds.
        send_dot(1'b0, 1'b1);
        send_dot(1'b1, 1'b0);
        write_vram(16'hffff, 8'hff);
        send_line(9'd511);
        send_line(9'd1);
        // Hires with everything at its top value, interlace on the odd field.
        write_reg(REG_SCREEN_MODE, 36'd5);
        write_reg(REG_LAYER_CTRL, 36'hff);
        write_reg(REG_SCROLL, 36'hfffff);
        write_reg(REG_PRIO_MOS, 36'hfff);
        send_dot(1'b1, 1'b1);
        send_dot(1'b1, 1'b1);
        send_dot(1'b0, 1'b0);
        // Offset-per-tile in modes 2 and 4, with a valid third layer entry at its map.
        write_reg(REG_SCREEN_MODE, 36'd2);
        write_reg(REG_LAYER_CTRL, 36'h61);
        write_reg(REG_PRIO_MOS, 36'h0f0);
        write_reg(REG_SCROLL, 36'h0);
        write_reg(REG_THIRD, 36'h3_0000_0000);
        write_vram(16'h3000, 8'h08);
        write_vram(16'h3001, 8'h20);
        send_line(9'd0);
        repeat (10) send_dot(1'b0, 1'b0);
        write_reg(REG_SCREEN_MODE, 36'd4);
        write_vram(16'h3001, 8'ha0);
        repeat (10) send_dot(1'b0, 1'b0);
        // Layer switched off draws nothing.
        write_reg(REG_LAYER_CTRL, 36'h00);
        send_dot(1'b0, 1'b0);
        write_reg(REG_UNUSED, 36'hf_ffff_ffff);
    endtask

    task automatic random_setting(input int unsigned setting);
        logic [35:0] wide;
        wide = {4'($urandom), 32'($urandom)};
        if (setting == 0)
        begin
            for (int r = 0; r < 8; r++)
                write_reg(3'(r), 36'hf_ffff_ffff);
        end
        else if (setting == 1)
        begin
            for (int r = 0; r < 7; r++)
                write_reg(3'(r), 36'h0);
            write_reg(REG_LAYER_CTRL, 36'h61);
        end
        else
        begin
            write_reg(REG_SCREEN_MODE, 36'($urandom_range(0, 7)));
            write_reg(REG_LAYER_CTRL, 36'({1'($urandom), 2'($urandom_range(1, 3)),
                                           3'($urandom), 2'($urandom_range(1, 3))}));
            write_reg(REG_TILE_DATA, 36'($urandom & 32'hf000));
            write_reg(REG_TILE_MAP, 36'($urandom & 32'hff00));
            write_reg(REG_PRIO_MOS, 36'($urandom & (($urandom_range(0, 3) == 0) ?
                                                   32'hfff : 32'h3ff)));
            write_reg(REG_SCROLL, 36'($urandom & (($urandom_range(0, 3) == 0) ?
                                                 32'hfffff : 32'h01c07)));
            write_reg(REG_THIRD, wide);
            write_reg(REG_UNUSED, 36'($urandom));
        end
    endtask

    // Paints the map, tile data and third layer map near their bases, then
    // draws short scanlines with a little noise mixed in.
    task automatic random_scene(input int unsigned requests);
        int unsigned n;
        int unsigned pick;
        n = 0;
        repeat (24)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: write_vram(map_base + 16'($urandom_range(0, 127)),
                              ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 15))
                                                          : 8'($urandom));
                1: write_vram(char_base + 16'($urandom_range(0, 255)), 8'($urandom));
                2: write_vram(bg3_source[35:20] + 16'($urandom_range(0, 127)), 8'($urandom));
                default: write_vram(16'($urandom), 8'($urandom));
            endcase
            n++;
        end
        while (n < requests)
        begin
            send_line(($urandom_range(0, 5) == 0) ? 9'($urandom) : 9'($urandom_range(0, 20)));
            n++;
            repeat ($urandom_range(4, 12))
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_request(MODE_UNUSED, 16'($urandom), 8'($urandom), 9'($urandom),
                                 1'($urandom), 1'($urandom));
                else if (pick < 3)
                    write_vram(char_base + 16'($urandom_range(0, 255)), 8'($urandom));
                else
                    send_dot(1'($urandom), 1'($urandom));
                n++;
            end
        end
    endtask

    task automatic test_random_scenes();
        for (int unsigned s = 0; s < 8; s++)
        begin
            random_setting(s);
            random_scene(55);
        end
    endtask

    // Back-to-back requests with neither side idling.
    task automatic test_steady_stream();
        random_setting(2);
        quiet = 1'b1;
        random_scene(40);
    endtask

    initial
    begin
        for (int i = 0; i < 65536; i++)
            vram[i] = '0;
        dot_count = '0;
        mosaic_row = '0;
        mosaic_left = '0;
        held = '{default: '0};
        bg_mode = '0;
        layer_ctrl = '0;
        char_base = '0;
        map_base = '0;
        prio_mosaic = '0;
        scroll = '0;
        bg3_source = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_directed_cases();
        test_random_scenes();
        test_steady_stream();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("Sent %0d requests and checked %0d results; %0d dots drew a pixel.",
                 requests_sent, results_seen, dots_drawn);
        $display("Settings covered all modes at random plus all-zero and all-one registers.");
        if (errors == 0)
            $display("tile_background_layer_dot verification clean");
        else
            $display("tile_background_layer_dot verification failed");
        $finish;
    end
endmodule
